>>> rtl/svsm_pkg.sv
// Shared types and constants for the shift vector string matcher.
package svsm_pkg;

  localparam int MAX_PATTERN_LEN = 64;
  localparam int IDX_W           = $clog2(MAX_PATTERN_LEN);
  localparam int LEN_W           = IDX_W + 1;
  localparam int BYTE_W          = 8;
  localparam int MODE_W          = 2;
  localparam int COUNT_W         = 32;
  localparam int QUEUE_DEPTH     = 4;
  localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

  localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TEXT  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_START = 2'd2;

  localparam logic [LEN_W-1:0]   LEN_MAX   = LEN_W'(MAX_PATTERN_LEN);
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_TEXT,
    OP_START,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0]  pidx;
    logic [BYTE_W-1:0] data;
  } item_t;

endpackage

>>> rtl/svsm_front.sv
// Front end: takes input beats, decodes the mode and stages one item.
module svsm_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [svsm_pkg::MODE_W-1:0] mode,
  input  logic [svsm_pkg::IDX_W-1:0]  pattern_index,
  input  logic [svsm_pkg::BYTE_W-1:0] data_byte,
  output logic                        push_valid,
  input  logic                        push_ready,
  output svsm_pkg::item_t             push_item
);

  logic            hold_valid;
  svsm_pkg::item_t hold_item;
  svsm_pkg::op_t   op_dec;

  always_comb begin
    case (mode)
      svsm_pkg::MODE_LOAD:  op_dec = svsm_pkg::OP_LOAD;
      svsm_pkg::MODE_TEXT:  op_dec = svsm_pkg::OP_TEXT;
      svsm_pkg::MODE_START: op_dec = svsm_pkg::OP_START;
      default:              op_dec = svsm_pkg::OP_NOP;
    endcase
  end

  assign in_ready   = !hold_valid || push_ready;
  assign push_valid = hold_valid;
  assign push_item  = hold_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_item.op   <= op_dec;
      hold_item.pidx <= pattern_index;
      hold_item.data <= data_byte;
    end
  end

endmodule

>>> rtl/svsm_queue.sv
// Short FIFO of decoded items between front and back.
module svsm_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  svsm_pkg::item_t push_item,
  output logic            pop_valid,
  input  logic            pop_ready,
  output svsm_pkg::item_t pop_item
);

  svsm_pkg::item_t                 slots [svsm_pkg::QUEUE_DEPTH];
  logic [svsm_pkg::QPTR_W-1:0]     wr_ptr;
  logic [svsm_pkg::QPTR_W-1:0]     rd_ptr;
  logic [svsm_pkg::QCNT_W-1:0]     fill;
  logic                            do_push;
  logic                            do_pop;

  assign push_ready = fill != svsm_pkg::QCNT_W'(svsm_pkg::QUEUE_DEPTH);
  assign pop_valid  = fill != '0;
  assign pop_item   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

>>> rtl/svsm_back.sv
// Back end: pattern store, match vector, count and result register.
module svsm_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [svsm_pkg::LEN_W-1:0]   cfg_wdata,
  input  logic                         pop_valid,
  output logic                         pop_ready,
  input  svsm_pkg::item_t              pop_item,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         match_here,
  output logic [svsm_pkg::COUNT_W-1:0] match_count
);

  logic [svsm_pkg::BYTE_W-1:0]          pat_byte [svsm_pkg::MAX_PATTERN_LEN];
  logic [svsm_pkg::MAX_PATTERN_LEN-1:0] pat_valid;
  logic [svsm_pkg::MAX_PATTERN_LEN-1:0] vec;
  logic [svsm_pkg::MAX_PATTERN_LEN-1:0] vec_next;
  logic [svsm_pkg::MAX_PATTERN_LEN-1:0] mask;
  logic [svsm_pkg::COUNT_W-1:0]         count;
  logic [svsm_pkg::COUNT_W-1:0]         count_next;
  logic [svsm_pkg::LEN_W-1:0]           plen;
  logic [svsm_pkg::LEN_W-1:0]           len_m1;
  logic [svsm_pkg::IDX_W-1:0]           top;
  logic                                 hit;
  logic                                 take;

  assign pop_ready = !out_valid || out_ready;
  assign take      = pop_valid && pop_ready;

  // effective length minus one: zero acts as one, clamp at the maximum
  always_comb begin
    if (plen == '0) begin
      len_m1 = '0;
    end else if (plen > svsm_pkg::LEN_MAX) begin
      len_m1 = svsm_pkg::LEN_MAX - 1'b1;
    end else begin
      len_m1 = plen - 1'b1;
    end
    top = len_m1[svsm_pkg::IDX_W-1:0];
  end

  always_comb begin
    for (int i = 0; i < svsm_pkg::MAX_PATTERN_LEN; i++) begin
      mask[i] = !(pat_valid[i] && (pat_byte[i] == pop_item.data));
    end
  end

  always_comb begin
    vec_next   = vec;
    count_next = count;
    hit        = 1'b0;
    case (pop_item.op)
      svsm_pkg::OP_TEXT: begin
        vec_next = (vec << 1) | mask;
        hit      = !vec_next[top];
        if (hit && (count != svsm_pkg::COUNT_MAX)) begin
          count_next = count + 1'b1;
        end
      end
      svsm_pkg::OP_START: begin
        vec_next   = '1;
        count_next = '0;
      end
      default: begin
        vec_next   = vec;
        count_next = count;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      plen      <= svsm_pkg::LEN_W'(1);
      pat_valid <= '0;
      vec       <= '1;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        plen <= cfg_wdata;
      end
      if (take) begin
        vec   <= vec_next;
        count <= count_next;
        if (pop_item.op == svsm_pkg::OP_LOAD) begin
          pat_valid[pop_item.pidx] <= 1'b1;
        end
      end
      if (pop_ready) begin
        out_valid <= pop_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (pop_item.op == svsm_pkg::OP_LOAD) begin
        pat_byte[pop_item.pidx] <= pop_item.data;
      end
      match_here  <= hit;
      match_count <= count_next;
    end
  end

endmodule

>>> rtl/shift_vector_string_matcher.sv
// Top level of the shift vector string matcher.
//
//   channel  | handshake            | payload
//   ---------+----------------------+------------------------------------
//   input    | in_valid / in_ready  | mode, pattern_index, data_byte
//   result   | out_valid / out_ready| match_here, match_count
//   config   | cfg_we               | cfg_wdata (pattern_length)
//
// One beat per cycle unless out_ready stalls; one mask compare and shift-or per
// text byte in the back end sets the rate. Beats pass front, queue and back registers.
// Synchronous reset empties the pipeline, clears the pattern valid bits,
// sets the vector to all ones, the count to zero and the length to one.
// A four-entry queue lets input and result sides stall independently.
module shift_vector_string_matcher (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [svsm_pkg::LEN_W-1:0]   cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [svsm_pkg::MODE_W-1:0]  mode,
  input  logic [svsm_pkg::IDX_W-1:0]   pattern_index,
  input  logic [svsm_pkg::BYTE_W-1:0]  data_byte,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         match_here,
  output logic [svsm_pkg::COUNT_W-1:0] match_count
);

  logic            push_valid;
  logic            push_ready;
  svsm_pkg::item_t push_item;
  logic            pop_valid;
  logic            pop_ready;
  svsm_pkg::item_t pop_item;

  svsm_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .mode          (mode),
    .pattern_index (pattern_index),
    .data_byte     (data_byte),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_item     (push_item)
  );

  svsm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  svsm_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_item    (pop_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .match_here  (match_here),
    .match_count (match_count)
  );

endmodule
